/* design/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* design/gcpe_pkg.sv */
// Package: payload types, the plan struct, register indexes, reset values.
`timescale 1ns / 1ps

package gcpe_pkg;

   localparam int BYTE_BITS = 8;
   localparam int COORD_W   = 16;
   localparam int COLOR_W   = 16;
   localparam int HEIGHT_W  = 8;
   localparam int CSR_IDX_W = 8;
   localparam int SEL_W     = $clog2(BYTE_BITS);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 8'd1;

   // Reset values
   localparam logic [COLOR_W-1:0]  FG_COLOR_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0]  BG_COLOR_RESET = 16'h0000;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 8'd1;

   typedef struct packed {
      logic                glyph_start;
      logic [COORD_W-1:0]  origin_x;
      logic [COORD_W-1:0]  origin_y;
      logic [HEIGHT_W-1:0] glyph_height;
      logic                transparent;
      logic [BYTE_BITS-1:0] font_byte;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_of_byte;
   } rsp_payload_type;

   // Work for one byte: bit j of the masks is the j-th pixel from the top
   typedef struct packed {
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [BYTE_BITS-1:0] write_mask;
      logic [BYTE_BITS-1:0] set_mask;
   } byte_plan_type;

endpackage

/* design/glyph_column_pixel_expander_core.sv */
// Glyph column pixel expander: top level with color registers.
// Each accepted font byte is planned in the cycle it transfers and then
// issues one pixel write per cycle, while the output is not stalled, from a
// single job register, topmost pixel first. A byte causes up to 8 writes
// (one column of 8 or more pixels in opaque mode), fewer at a column end or
// for clear bits in transparent mode, and a byte with no writes causes none.
// The next byte is accepted in the cycle the previous byte's last write
// leaves the job register, while that write waits in the output register,
// so a steady stream yields one write per cycle while rsp_ready stays high.
// Colors are written through the csr_ channel, index 0 for the foreground
// and 1 for the background; it is always ready.
`timescale 1ns / 1ps

module glyph_column_pixel_expander_core
   import gcpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);

   logic [COLOR_W-1:0] fg_color_ff;
   logic [COLOR_W-1:0] bg_color_ff;
   logic               req_xfer;
   logic               load_ready;
   byte_plan_type      plan;

   assign csr_ready = 1'b1;
   assign req_ready = load_ready;
   assign req_xfer  = req_valid && load_ready;

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff <= FG_COLOR_RESET;
         bg_color_ff <= BG_COLOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_color_ff <= csr_data;
            CSR_BG_COLOR: bg_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gcpe_planner u_planner (
      .clock    (clock),
      .reset    (reset),
      .load     (req_xfer),
      .req_data (req_data),
      .plan     (plan)
   );

   gcpe_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (req_xfer),
      .plan       (plan),
      .fg_color   (fg_color_ff),
      .bg_color   (bg_color_ff),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* design/gcpe_planner.sv */
// Column tracker: holds the glyph position and plans the writes of each byte.
`timescale 1ns / 1ps

module gcpe_planner
   import gcpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  req_payload_type req_data,
   output byte_plan_type   plan
);

   logic [COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]   top_y_ff, top_y_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic                 transp_ff, transp_in;

   logic [COORD_W-1:0]   eff_x;
   logic [COORD_W-1:0]   eff_y;
   logic [COORD_W-1:0]   row_offset;
   logic [BYTE_BITS-1:0] hit;
   logic [BYTE_BITS-1:0] active;
   logic [BYTE_BITS-1:0] set_bits;

   // Take the new origin on a glyph start, the latched position otherwise
   always_comb begin
      if (req_data.glyph_start) begin
         eff_x     = req_data.origin_x;
         eff_y     = req_data.origin_y;
         top_y_in  = req_data.origin_y;
         height_in = req_data.glyph_height;
         transp_in = req_data.transparent;
      end else begin
         eff_x     = cur_x_ff;
         eff_y     = cur_y_ff;
         top_y_in  = top_y_ff;
         height_in = height_ff;
         transp_in = transp_ff;
      end
      row_offset = eff_y - top_y_in;
   end

   // Find the column end and mark the bits up to and including it
   always_comb begin
      for (int j = 0; j < BYTE_BITS; j++) begin
         hit[j]      = (row_offset + COORD_W'(j + 1)) ==
                       {{(COORD_W-HEIGHT_W){1'b0}}, height_in};
         set_bits[j] = req_data.font_byte[BYTE_BITS-1-j];
      end
      active[0] = 1'b1;
      for (int j = 1; j < BYTE_BITS; j++) begin
         active[j] = active[j-1] & ~hit[j-1];
      end
   end

   // Column end returns to the top and steps right; else rows advance by a byte
   always_comb begin
      if (|hit) begin
         cur_x_in = eff_x + COORD_W'(1);
         cur_y_in = top_y_in;
      end else begin
         cur_x_in = eff_x;
         cur_y_in = eff_y + COORD_W'(BYTE_BITS);
      end
      plan.x          = eff_x;
      plan.y          = eff_y;
      plan.set_mask   = set_bits;
      plan.write_mask = active & (set_bits | {BYTE_BITS{~transp_in}});
   end

   // Advance the position on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         top_y_ff  <= '0;
         height_ff <= HEIGHT_RESET;
         transp_ff <= 1'b0;
      end else if (load) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         top_y_ff  <= top_y_in;
         height_ff <= height_in;
         transp_ff <= transp_in;
      end
   end

endmodule

/* design/gcpe_emitter.sv */
// Pixel emitter: holds one planned byte, issues its writes one per cycle unless stalled.
`timescale 1ns / 1ps

module gcpe_emitter
   import gcpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  byte_plan_type      plan,
   input  logic [COLOR_W-1:0] fg_color,
   input  logic [COLOR_W-1:0] bg_color,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_payload_type    rsp_data
);

   logic [COORD_W-1:0]   job_x_ff;
   logic [COORD_W-1:0]   job_y_ff;
   logic [BYTE_BITS-1:0] job_set_ff;
   logic [BYTE_BITS-1:0] job_mask_ff, job_mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff;

   logic [SEL_W-1:0]     sel_idx;
   logic                 sel_found;
   logic [BYTE_BITS-1:0] mask_rest;
   logic                 pop;

   // Pick the topmost pending write
   always_comb begin
      sel_idx   = '0;
      sel_found = 1'b0;
      for (int j = 0; j < BYTE_BITS; j++) begin
         if (job_mask_ff[j] && !sel_found) begin
            sel_idx   = SEL_W'(j);
            sel_found = 1'b1;
         end
      end
      mask_rest = job_mask_ff & (job_mask_ff - BYTE_BITS'(1));
   end

   // Pop into the output slot when it is free or being drained
   always_comb begin
      pop          = (|job_mask_ff) && (!rsp_valid_ff || rsp_ready);
      load_ready   = (job_mask_ff == '0) || (pop && (mask_rest == '0));
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
      if (load) begin
         job_mask_in = plan.write_mask;
      end else if (pop) begin
         job_mask_in = mask_rest;
      end else begin
         job_mask_in = job_mask_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_mask_ff  <= job_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job and output payload
   always_ff @(posedge clock) begin
      if (load) begin
         job_x_ff   <= plan.x;
         job_y_ff   <= plan.y;
         job_set_ff <= plan.set_mask;
      end
      if (pop) begin
         rsp_data_ff.pixel_x      <= job_x_ff;
         rsp_data_ff.pixel_y      <= job_y_ff + COORD_W'(sel_idx);
         rsp_data_ff.pixel_color  <= job_set_ff[sel_idx] ? fg_color : bg_color;
         rsp_data_ff.last_of_byte <= (mask_rest == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/gcpe_checker.sv */
// Port checker for the glyph column pixel expander, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcpe_checker
   import gcpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_payload_type      rsp_data
);

   logic rsp_xfer;
   logic rsp_mid_byte;
   logic rsp_stall;
   logic rsp_step;

   assign rsp_xfer     = rsp_valid && rsp_ready;
   assign rsp_mid_byte = rsp_valid && !rsp_data.last_of_byte;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_step     = rsp_xfer && rsp_mid_byte;

   // A stalled write holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // Writes of one byte follow with no gap
   `ASSERT_NEXT(a_byte_no_gap, clock, reset, rsp_step, rsp_valid)

   // Writes of one byte stay in one column
   `ASSERT_NEXT(a_byte_same_col, clock, reset, rsp_step, rsp_data.pixel_x == $past(rsp_data.pixel_x))

   // No new byte while a stalled write has more of its byte behind it
   `ASSERT_IMPLIES(a_no_accept_mid_byte, clock, reset, rsp_mid_byte && !rsp_ready, !req_ready)

endmodule

bind glyph_column_pixel_expander_core gcpe_checker u_gcpe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
